// ----- rtl/lenode_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the leader election node.
// Used by lenode_ctrl, lenode_dp and leader_election_node_core; no dependencies.
package lenode_pkg;

   localparam int MAX_NODES  = 16;
   localparam int TIMER_BITS = 16;
   localparam int LFSR_BITS  = 16;
   localparam int EPOCH_BITS = 32;
   localparam int VOTE_BITS  = $clog2(MAX_NODES + 1);
   localparam int STEP_BITS  = $clog2(LFSR_BITS);
   localparam int CLAMP_BITS = (TIMER_BITS > 17) ? TIMER_BITS : 17;
   localparam int ADDR_BITS  = 5;

   localparam logic [VOTE_BITS-1:0]  VOTE_CAP  = VOTE_BITS'(MAX_NODES);
   localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(LFSR_BITS - 1);
   localparam logic [CLAMP_BITS-1:0] TIMER_MAX = CLAMP_BITS'({TIMER_BITS{1'b1}});
   localparam logic [LFSR_BITS-1:0]  LFSR_TAPS = 16'hB400;

   // Roles
   localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
   localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
   localparam logic [1:0] ROLE_LEADER    = 2'd2;

   // Outgoing message kinds
   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_REQUEST = 2'd1;
   localparam logic [1:0] SEND_BEAT    = 2'd2;
   localparam logic [1:0] SEND_VOTE    = 2'd3;

   // Received message kinds
   localparam logic [1:0] MSG_BEAT    = 2'd0;
   localparam logic [1:0] MSG_REQUEST = 2'd1;
   localparam logic [1:0] MSG_VOTE    = 2'd2;

   // Input commands
   localparam logic CMD_MESSAGE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [4:0] NO_LEADER = 5'd16;

   // Register indexes
   localparam logic [2:0] REG_OWN_ID      = 3'd0;
   localparam logic [2:0] REG_QUORUM      = 3'd1;
   localparam logic [2:0] REG_MIN_WAIT    = 3'd2;
   localparam logic [2:0] REG_MAX_WAIT    = 3'd3;
   localparam logic [2:0] REG_BEAT_PERIOD = 3'd4;
   localparam logic [2:0] REG_SEED        = 3'd5;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic div_last;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_stat_type;

   function automatic logic [TIMER_BITS-1:0] clamp_timer(input logic [16:0] v);
      logic [CLAMP_BITS-1:0] ext;
      ext = CLAMP_BITS'(v);
      if (ext > TIMER_MAX) begin
         return TIMER_BITS'(TIMER_MAX);
      end
      return TIMER_BITS'(ext);
   endfunction

   localparam logic [TIMER_BITS-1:0] COUNT_RESET = clamp_timer(17'd150);

endpackage

// ----- rtl/lenode_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the leader election node: evaluate, remainder steps, publish.
// Depends on lenode_pkg.
module lenode_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  lenode_pkg::dp_stat_type  stat,
   output lenode_pkg::ctrl_cmd_type cmd
);
   import lenode_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_FINISH
   } state_type;

   state_type            state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.eval     = (state_ff == S_EVAL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.div_last = (state_ff == S_DIV) && (step_ff == STEP_LAST);
      // The output register may be refilled in the cycle its word is taken.
      cmd.publish  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               step_ff  <= '0;
               state_ff <= stat.need_div ? S_DIV : S_FINISH;
            end
            S_DIV: begin
               step_ff <= step_ff + STEP_BITS'(1);
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.publish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/lenode_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the leader election node: node state, role rules, LFSR,
// bit-serial remainder unit and output register. Depends on lenode_pkg.
module lenode_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  lenode_pkg::ctrl_cmd_type cmd,
   output lenode_pkg::dp_stat_type  stat,
   input  logic                     req_command,
   input  logic [1:0]               req_msg_kind,
   input  logic [3:0]               req_sender,
   input  logic [31:0]              req_sender_epoch,
   input  logic [3:0]               own_id,
   input  logic [4:0]               quorum,
   input  logic [15:0]              min_wait,
   input  logic [15:0]              max_wait,
   input  logic [15:0]              beat_period,
   input  logic                     seed_wr,
   input  logic [15:0]              seed,
   output logic [1:0]               rsp_send_kind,
   output logic [3:0]               rsp_send_to,
   output logic [31:0]              rsp_send_epoch,
   output logic [1:0]               rsp_send_role,
   output logic [1:0]               rsp_role_now,
   output logic [31:0]              rsp_epoch_now,
   output logic [4:0]               rsp_known_leader,
   output logic [4:0]               rsp_vote_tally,
   output logic                     rsp_accepted,
   output logic                     rsp_fault
);
   import lenode_pkg::*;

   // Node state
   logic [1:0]            role_ff,   role_in;
   logic [EPOCH_BITS-1:0] epoch_ff,  epoch_in;
   logic [VOTE_BITS-1:0]  votes_ff,  votes_in;
   logic [4:0]            leader_ff, leader_in;
   logic [TIMER_BITS-1:0] count_ff,  count_in;
   logic [LFSR_BITS-1:0]  lfsr_ff,   lfsr_in;

   // Captured input word
   logic                  cmd_ff;
   logic [1:0]            kind_ff;
   logic [3:0]            sender_ff;
   logic [EPOCH_BITS-1:0] sepoch_ff;

   // Result fields formed during evaluation
   logic [1:0]            wk_kind_ff, wk_kind_in;
   logic [3:0]            wk_to_ff,   wk_to_in;
   logic [EPOCH_BITS-1:0] wk_ep_ff,   wk_ep_in;
   logic [1:0]            wk_role_ff, wk_role_in;
   logic                  wk_acc_ff,  wk_acc_in;
   logic                  wk_flt_ff,  wk_flt_in;

   // Remainder unit
   logic [15:0]           rem_ff, rem_in;
   logic [LFSR_BITS-1:0]  dvd_ff;
   logic [16:0]           trial;

   // Output register
   logic [1:0]            out_kind_ff;
   logic [3:0]            out_to_ff;
   logic [EPOCH_BITS-1:0] out_ep_ff;
   logic [1:0]            out_srole_ff;
   logic [1:0]            out_role_ff;
   logic [EPOCH_BITS-1:0] out_epoch_ff;
   logic [4:0]            out_leader_ff;
   logic [VOTE_BITS-1:0]  out_votes_ff;
   logic                  out_acc_ff;
   logic                  out_flt_ff;

   logic                  draw;
   logic                  has_span;
   logic [15:0]           span;
   logic [VOTE_BITS-1:0]  votes_inc;

   assign span     = max_wait - min_wait;
   assign has_span = (max_wait > min_wait);
   assign lfsr_in  = {1'b0, lfsr_ff[LFSR_BITS-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign votes_inc = (votes_ff < VOTE_CAP) ? votes_ff + VOTE_BITS'(1) : votes_ff;

   always_comb begin
      role_in    = role_ff;
      epoch_in   = epoch_ff;
      votes_in   = votes_ff;
      leader_in  = leader_ff;
      count_in   = count_ff;
      wk_kind_in = SEND_NONE;
      wk_to_in   = '0;
      wk_ep_in   = '0;
      wk_role_in = ROLE_FOLLOWER;
      wk_acc_in  = 1'b0;
      wk_flt_in  = 1'b0;
      draw       = 1'b0;
      if (cmd_ff == CMD_TICK) begin
         if (count_ff <= TIMER_BITS'(1)) begin
            if (role_ff == ROLE_LEADER) begin
               wk_kind_in = SEND_BEAT;
               wk_ep_in   = epoch_ff;
               wk_role_in = ROLE_LEADER;
               count_in   = clamp_timer({1'b0, beat_period});
            end else begin
               role_in    = ROLE_CANDIDATE;
               epoch_in   = (epoch_ff != '1) ? epoch_ff + EPOCH_BITS'(1) : epoch_ff;
               votes_in   = VOTE_BITS'(1);
               wk_kind_in = SEND_REQUEST;
               wk_ep_in   = epoch_in;
               wk_role_in = ROLE_CANDIDATE;
               draw       = 1'b1;
            end
         end else begin
            count_in = count_ff - TIMER_BITS'(1);
         end
      end else if (sepoch_ff >= epoch_ff) begin
         wk_acc_in = 1'b1;
         if (role_ff == ROLE_FOLLOWER) begin
            if (kind_ff == MSG_BEAT) begin
               leader_in = {1'b0, sender_ff};
               epoch_in  = sepoch_ff;
            end else if (kind_ff == MSG_REQUEST && sepoch_ff > epoch_ff) begin
               epoch_in   = sepoch_ff;
               wk_kind_in = SEND_VOTE;
               wk_to_in   = sender_ff;
               wk_ep_in   = sepoch_ff;
               wk_role_in = ROLE_FOLLOWER;
            end
         end else begin
            if ((kind_ff == MSG_REQUEST && sepoch_ff > epoch_ff) || kind_ff == MSG_BEAT) begin
               epoch_in = sepoch_ff;
               role_in  = ROLE_FOLLOWER;
            end else if (kind_ff == MSG_REQUEST) begin
               // A request at the same term leaves role and term unchanged.
               role_in = role_ff;
            end else if (role_ff == ROLE_CANDIDATE) begin
               if (kind_ff == MSG_VOTE) begin
                  votes_in = votes_inc;
                  if (votes_inc >= quorum) begin
                     role_in   = ROLE_LEADER;
                     leader_in = {1'b0, own_id};
                  end
               end
            end else begin
               wk_flt_in = 1'b1;
            end
         end
         if (role_in == ROLE_LEADER) begin
            count_in = clamp_timer({1'b0, beat_period});
         end else begin
            draw = 1'b1;
         end
      end
      // Without a span the draw is plain min_wait; otherwise the remainder unit loads it.
      if (draw && !has_span) begin
         count_in = clamp_timer({1'b0, min_wait});
      end
      stat.need_div = draw && has_span;
   end

   // One restoring step per cycle, MSB of the LFSR value first.
   always_comb begin
      trial = {rem_ff, dvd_ff[LFSR_BITS-1]};
      if (trial >= {1'b0, span}) begin
         rem_in = 16'(trial - {1'b0, span});
      end else begin
         rem_in = trial[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff   <= ROLE_FOLLOWER;
         epoch_ff  <= '0;
         votes_ff  <= '0;
         leader_ff <= NO_LEADER;
         count_ff  <= COUNT_RESET;
         lfsr_ff   <= 16'd44257;
      end else begin
         if (seed_wr) begin
            lfsr_ff <= seed;
         end else if (cmd.eval && draw) begin
            lfsr_ff <= lfsr_in;
         end
         if (cmd.eval) begin
            role_ff   <= role_in;
            epoch_ff  <= epoch_in;
            votes_ff  <= votes_in;
            leader_ff <= leader_in;
            count_ff  <= count_in;
         end else if (cmd.div_last) begin
            count_ff <= clamp_timer({1'b0, min_wait} + {1'b0, rem_in});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         kind_ff   <= req_msg_kind;
         sender_ff <= req_sender;
         sepoch_ff <= req_sender_epoch;
      end
      if (cmd.eval) begin
         wk_kind_ff <= wk_kind_in;
         wk_to_ff   <= wk_to_in;
         wk_ep_ff   <= wk_ep_in;
         wk_role_ff <= wk_role_in;
         wk_acc_ff  <= wk_acc_in;
         wk_flt_ff  <= wk_flt_in;
         rem_ff     <= '0;
         dvd_ff     <= lfsr_in;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[LFSR_BITS-2:0], 1'b0};
      end
      if (cmd.publish) begin
         out_kind_ff   <= wk_kind_ff;
         out_to_ff     <= wk_to_ff;
         out_ep_ff     <= wk_ep_ff;
         out_srole_ff  <= wk_role_ff;
         out_role_ff   <= role_ff;
         out_epoch_ff  <= epoch_ff;
         out_leader_ff <= leader_ff;
         out_votes_ff  <= votes_ff;
         out_acc_ff    <= wk_acc_ff;
         out_flt_ff    <= wk_flt_ff;
      end
   end

   assign rsp_send_kind    = out_kind_ff;
   assign rsp_send_to      = out_to_ff;
   assign rsp_send_epoch   = out_ep_ff;
   assign rsp_send_role    = out_srole_ff;
   assign rsp_role_now     = out_role_ff;
   assign rsp_epoch_now    = out_epoch_ff;
   assign rsp_known_leader = out_leader_ff;
   assign rsp_vote_tally   = 5'(out_votes_ff);
   assign rsp_accepted     = out_acc_ff;
   assign rsp_fault        = out_flt_ff;

endmodule

// ----- rtl/leader_election_node_core.sv -----
`timescale 1ns / 1ps
// Leader election node: a word's result is registered once it has been evaluated and, when a
// random timeout is drawn, once the one-bit-a-cycle remainder unit has reduced the LFSR value
// by the wait span; the output register waits while its previous word is not yet taken. One
// word is in work at a time; the next is accepted once the result is registered. Synchronous
// reset restores node state, sequencer and settings, not the captured word or result registers.
module leader_election_node_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_msg_kind,
   input  logic [3:0]  req_sender,
   input  logic [31:0] req_sender_epoch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_send_kind,
   output logic [3:0]  rsp_send_to,
   output logic [31:0] rsp_send_epoch,
   output logic [1:0]  rsp_send_role,
   output logic [1:0]  rsp_role_now,
   output logic [31:0] rsp_epoch_now,
   output logic [4:0]  rsp_known_leader,
   output logic [4:0]  rsp_vote_tally,
   output logic        rsp_accepted,
   output logic        rsp_fault,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [lenode_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lenode_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   logic [3:0]  own_id_ff;
   logic [4:0]  quorum_ff;
   logic [15:0] min_wait_ff;
   logic [15:0] max_wait_ff;
   logic [15:0] beat_period_ff;
   logic [15:0] seed_ff;
   logic [2:0]  reg_index;
   logic        reg_write;
   logic        seed_wr;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign reg_write = psel && penable && pwrite;
   assign seed_wr   = reg_write && (reg_index == REG_SEED);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff      <= 4'd0;
         quorum_ff      <= 5'd2;
         min_wait_ff    <= 16'd150;
         max_wait_ff    <= 16'd300;
         beat_period_ff <= 16'd50;
         seed_ff        <= 16'd44257;
      end else if (reg_write) begin
         case (reg_index)
            REG_OWN_ID:      own_id_ff      <= pwdata[3:0];
            REG_QUORUM:      quorum_ff      <= pwdata[4:0];
            REG_MIN_WAIT:    min_wait_ff    <= pwdata[15:0];
            REG_MAX_WAIT:    max_wait_ff    <= pwdata[15:0];
            REG_BEAT_PERIOD: beat_period_ff <= pwdata[15:0];
            REG_SEED:        seed_ff        <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_OWN_ID:      prdata = {28'd0, own_id_ff};
         REG_QUORUM:      prdata = {27'd0, quorum_ff};
         REG_MIN_WAIT:    prdata = {16'd0, min_wait_ff};
         REG_MAX_WAIT:    prdata = {16'd0, max_wait_ff};
         REG_BEAT_PERIOD: prdata = {16'd0, beat_period_ff};
         REG_SEED:        prdata = {16'd0, seed_ff};
         default:         prdata = '0;
      endcase
   end

   lenode_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lenode_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_msg_kind     (req_msg_kind),
      .req_sender       (req_sender),
      .req_sender_epoch (req_sender_epoch),
      .own_id           (own_id_ff),
      .quorum           (quorum_ff),
      .min_wait         (min_wait_ff),
      .max_wait         (max_wait_ff),
      .beat_period      (beat_period_ff),
      .seed_wr          (seed_wr),
      .seed             (pwdata[15:0]),
      .rsp_send_kind    (rsp_send_kind),
      .rsp_send_to      (rsp_send_to),
      .rsp_send_epoch   (rsp_send_epoch),
      .rsp_send_role    (rsp_send_role),
      .rsp_role_now     (rsp_role_now),
      .rsp_epoch_now    (rsp_epoch_now),
      .rsp_known_leader (rsp_known_leader),
      .rsp_vote_tally   (rsp_vote_tally),
      .rsp_accepted     (rsp_accepted),
      .rsp_fault        (rsp_fault)
   );

   // A vote is only ever sent by a follower that took the request.
   a_vote_from_follower : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == SEND_VOTE |->
         rsp_role_now == ROLE_FOLLOWER && rsp_accepted)
      else $error("vote sent by a node that is not a follower");

   a_fault_only_leader : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_role_now == ROLE_LEADER && rsp_accepted)
      else $error("fault reported outside the leader role");

   a_request_opens_candidacy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind == SEND_REQUEST |->
         rsp_role_now == ROLE_CANDIDATE && rsp_vote_tally == 5'd1 && !rsp_accepted)
      else $error("election request without a fresh candidacy");

   a_one_word_in_work : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while one is in work");

endmodule
